// ===== src/bpeq_pkg.sv =====
// shared types and constants of the bounded priority event queue
// no dependencies

package bpeq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int PRIORITY_COUNT = 8;

   localparam int CODE_W    = 4;
   localparam int PRIO_W    = 3;
   localparam int CAP_W     = 5;
   localparam int COUNT_W   = 5;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [PRIO_W-1:0] PRIO_MAX =
      (PRIORITY_COUNT > (1 << PRIO_W)) ? {PRIO_W{1'b1}} : PRIO_W'(PRIORITY_COUNT - 1);

   // register indexes on the word address
   localparam logic REG_CAPACITY = 1'b0;

   // item kinds on req_tuser
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [CODE_W-1:0] code;
   } entry_type;

endpackage

// ===== src/bpeq_ram.sv =====
// generic single write port ram with one registered read port
// depends on bpeq_pkg for default sizes

module bpeq_ram #(
   parameter int WIDTH = $bits(bpeq_pkg::entry_type),
   parameter int DEPTH = bpeq_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bounded_priority_event_queue_top.sv =====
// top level of the bounded priority event queue: sequencer, count and capacity register
// depends on bpeq_pkg and bpeq_ram

// The queue keeps its entries sorted by priority, head in slot 0, in one ram with a
// registered read and one write per cycle. An item is taken only while the sequencer
// is idle. A pop reads the head and then moves every remaining entry up one slot, one
// slot per cycle. An insert walks from the tail toward the head, moving each entry of
// lower priority down one slot per cycle. The result waits in an output register, so
// the next item is accepted while it does.

module bounded_priority_event_queue_top #(
   parameter int QUEUE_DEPTH = bpeq_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // process_code, priority_level
   input  logic                            req_tuser,   // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // popped_code, popped_priority, entry_count
   output logic [1:0]                      rsp_tuser,   // popped_valid, insert_dropped
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bpeq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bpeq_pkg::CSR_W-1:0]      csr_pwdata,
   output logic [bpeq_pkg::CSR_W-1:0]      csr_prdata,
   output logic                            csr_pready
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int W  = (CW > bpeq_pkg::CAP_W) ? CW : bpeq_pkg::CAP_W;
   localparam int EW = $bits(bpeq_pkg::entry_type);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_POP_HEAD  = 6'b000010,
      ST_POP_SHIFT = 6'b000100,
      ST_INS_WALK  = 6'b001000,
      ST_INS_PLACE = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                held_ff, held_in;
   logic [bpeq_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic                         mode_ff, mode_in;
   bpeq_pkg::entry_type          new_ff, new_in;
   bpeq_pkg::entry_type          pop_ff, pop_in;
   logic                         pop_valid_ff, pop_valid_in;
   logic                         drop_ff, drop_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [15:0]                  rsp_data_ff, rsp_data_in;
   logic [1:0]                   rsp_user_ff, rsp_user_in;

   logic                         accept;
   logic                         full;
   logic [bpeq_pkg::PRIO_W-1:0]  in_prio;
   logic [CW-1:0]                held_next;
   logic                         csr_write;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   bpeq_pkg::entry_type          wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   bpeq_pkg::entry_type          rd_data;

   bpeq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_prio    = (req_tdata[6:4] > bpeq_pkg::PRIO_MAX) ? bpeq_pkg::PRIO_MAX
                                                             : req_tdata[6:4];
   assign full       = (W'(held_ff) >= W'(cap_ff)) || (W'(held_ff) >= W'(QUEUE_DEPTH));

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == bpeq_pkg::REG_CAPACITY)
                     ? bpeq_pkg::CSR_W'(cap_ff) : '0;
   assign cap_in     = (csr_write && csr_paddr[2] == bpeq_pkg::REG_CAPACITY)
                     ? csr_pwdata[bpeq_pkg::CAP_W-1:0] : cap_ff;

   always_comb begin
      if (mode_ff == bpeq_pkg::MODE_INSERT && !drop_ff) begin
         held_next = held_ff + 1'b1;
      end else if (mode_ff == bpeq_pkg::MODE_POP && pop_valid_ff) begin
         held_next = held_ff - 1'b1;
      end else begin
         held_next = held_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      mode_in      = mode_ff;
      new_in       = new_ff;
      pop_in       = pop_ff;
      pop_valid_in = pop_valid_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = new_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in      = req_tuser;
               new_in.code  = req_tdata[3:0];
               new_in.prio  = in_prio;
               pop_in       = '0;
               pop_valid_in = 1'b0;
               drop_in      = 1'b0;
               if (req_tuser == bpeq_pkg::MODE_POP) begin
                  if (held_ff == '0) begin
                     state_in = ST_FINISH;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_POP_HEAD;
                  end
               end else if (full) begin
                  drop_in  = 1'b1;
                  state_in = ST_FINISH;
               end else if (held_ff == '0) begin
                  wr_en        = 1'b1;
                  wr_addr      = '0;
                  wr_data.code = req_tdata[3:0];
                  wr_data.prio = in_prio;
                  state_in     = ST_FINISH;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(held_ff - 1'b1);
                  idx_in   = AW'(held_ff);
                  state_in = ST_INS_WALK;
               end
            end
         end
         ST_POP_HEAD: begin
            pop_in       = rd_data;
            pop_valid_in = 1'b1;
            if (held_ff > CW'(1)) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               idx_in   = AW'(1);
               state_in = ST_POP_SHIFT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_POP_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - 1'b1;
            wr_data = rd_data;
            if ((CW'(idx_ff) + CW'(1)) < held_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_INS_WALK: begin
            wr_en = 1'b1;
            if (rd_data.prio < new_ff.prio) begin
               wr_data = rd_data;
               if (idx_ff == AW'(1)) begin
                  idx_in   = '0;
                  state_in = ST_INS_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(2);
                  idx_in  = idx_ff - 1'b1;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_INS_PLACE: begin
            wr_en    = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, bpeq_pkg::COUNT_W'(held_next), pop_ff.prio, pop_ff.code};
               rsp_user_in  = {drop_ff, pop_valid_ff};
               held_in      = held_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         cap_ff       <= bpeq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      mode_ff      <= mode_in;
      new_ff       <= new_in;
      pop_ff       <= pop_in;
      pop_valid_ff <= pop_valid_in;
      drop_ff      <= drop_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== src/bpeq_checker.sv =====
// port-level checks of the bounded priority event queue, bound to the top level
// depends on bounded_priority_event_queue_top

module bpeq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("pop and drop flagged together");

   // no entry removed means empty popped fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[6:0] == 7'd0)
      else $error("popped fields set without a pop");

endmodule

bind bounded_priority_event_queue_top bpeq_checker u_bpeq_checker (.*);
